// File: rtl/mtbl_pkg.sv
// ----------------------------------------------------------------------------
// mtbl_pkg: shared types and helpers for the multi token bucket limiter
// Holds the transaction structs, operation and status codes, the packet
// that walks the bucket cell chain, and the counter arithmetic helpers.
// ----------------------------------------------------------------------------
package mtbl_pkg;

  localparam int unsigned BUCKETS  = 16;
  localparam int unsigned TOKEN_W  = 16;

  localparam int unsigned IDX_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned CNT_W    = $clog2(BUCKETS + 1);
  localparam int unsigned CMP_W    = (CNT_W > 4) ? CNT_W : 4;
  localparam int unsigned SUM_W    = ((TOKEN_W > 16) ? TOKEN_W : 16) + 1;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_CREATE = 2'd1,
    ACT_FETCH  = 2'd2,
    ACT_RETURN = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  typedef struct packed {
    action_e     action;
    logic [3:0]  bucket;
    logic [15:0] rate;
    logic [15:0] burst_limit;
    logic [15:0] amount;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  new_index;
    logic [15:0] granted;
  } out_t;

  // Packet handed from cell to cell. The result fields fill in on the way.
  typedef struct packed {
    action_e          action;
    logic [IDX_W-1:0] target;
    logic [CNT_W-1:0] count;
    logic [15:0]      rate;
    logic [15:0]      burst;
    logic [15:0]      amount;
    status_e          status;
    logic [3:0]       new_index;
    logic [15:0]      granted;
  } pkt_t;

  // Saturates a widened sum to the token counter maximum.
  function automatic logic [TOKEN_W-1:0] clamp_tok(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] lim;
    lim = SUM_W'({TOKEN_W{1'b1}});
    if (v > lim) begin
      return {TOKEN_W{1'b1}};
    end else begin
      return v[TOKEN_W-1:0];
    end
  endfunction

  // Saturates a token count to the 16-bit grant field.
  function automatic logic [15:0] sat_grant(input logic [TOKEN_W-1:0] t);
    logic [SUM_W-1:0] w;
    w = SUM_W'(t);
    if (w > SUM_W'(16'hFFFF)) begin
      return 16'hFFFF;
    end else begin
      return w[15:0];
    end
  endfunction

endpackage

// File: rtl/mtbl_cell.sv
// ----------------------------------------------------------------------------
// mtbl_cell: one bucket of the limiter
// Holds the rate, burst limit and token count of one bucket, applies the
// passing packet to them and hands the packet on to the next cell.
// ----------------------------------------------------------------------------
module mtbl_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [mtbl_pkg::IDX_W-1:0] cell_idx_i,
  input  logic                      valid_i,
  input  mtbl_pkg::pkt_t            pkt_i,
  output logic                      valid_o,
  output mtbl_pkg::pkt_t            pkt_o
);
  import mtbl_pkg::*;

  logic [15:0]      rate_q, rate_d;
  logic [15:0]      burst_q, burst_d;
  logic [TOKEN_W-1:0] tok_q, tok_d;
  logic             valid_q;
  pkt_t             pkt_q, pkt_d;
  logic             hit;
  logic             live;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] cap;
  logic [SUM_W-1:0] ret_sum;

  assign hit     = (pkt_i.status == ST_OK) && (pkt_i.target == cell_idx_i);
  assign live    = (pkt_i.status == ST_OK) && (CNT_W'(cell_idx_i) < pkt_i.count);
  assign sum     = SUM_W'(tok_q) + SUM_W'(rate_q);
  assign cap     = SUM_W'(burst_q);
  assign ret_sum = SUM_W'(tok_q) + SUM_W'(pkt_i.amount);

  always_comb begin
    pkt_d   = pkt_i;
    rate_d  = rate_q;
    burst_d = burst_q;
    tok_d   = tok_q;
    unique case (pkt_i.action)
      ACT_TICK: begin
        if (live) begin
          tok_d = clamp_tok((sum < cap) ? sum : cap);
        end
      end
      ACT_CREATE: begin
        if (hit) begin
          rate_d  = pkt_i.rate;
          burst_d = pkt_i.burst;
          tok_d   = '0;
        end
      end
      ACT_FETCH: begin
        if (hit) begin
          if (tok_q == '0) begin
            pkt_d.status = ST_EMPTY;
          end else begin
            pkt_d.granted = sat_grant(tok_q);
            tok_d         = '0;
          end
        end
      end
      ACT_RETURN: begin
        if (hit) begin
          tok_d = clamp_tok(ret_sum);
        end
      end
      default: begin
        pkt_d = pkt_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pkt_q <= pkt_d;
      if (valid_i) begin
        rate_q  <= rate_d;
        burst_q <= burst_d;
        tok_q   <= tok_d;
      end
    end
  end

  assign valid_o = valid_q;
  assign pkt_o   = pkt_q;

endmodule

// File: rtl/multi_token_bucket_limiter.sv
// ----------------------------------------------------------------------------
// multi_token_bucket_limiter: a bank of token buckets
// Each transaction carries one operation: tick refills every created bucket
// up to its burst limit, create appends a bucket and reports its index,
// fetch hands out all tokens of one bucket, and return gives tokens back,
// saturating at the counter maximum. Each bucket lives in its own cell of a
// chain with one register stage per cell, and a transaction walks the chain
// one cell per cycle unless the chain is held, so every operation, a tick
// included, reaches each bucket in turn. Transactions follow each other
// into the chain in back to back cycles: the sustained rate is one transaction
// per cycle unless the output stalls, and the result leaves the last cell
// of the chain. A stalled result at the end of the chain holds the whole
// chain and stalls the input. The bucket tables have no reset; only buckets
// that create has written are ever read, since indices at or above the
// bucket count are rejected with an error status at the input.
// ----------------------------------------------------------------------------
module multi_token_bucket_limiter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mtbl_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mtbl_pkg::out_t out_data_o
);
  import mtbl_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic             en;
  logic             accept;
  logic             full;
  logic             bad_idx;
  pkt_t             entry;
  pkt_t             chain_pkt [BUCKETS+1];
  logic             chain_vld [BUCKETS+1];

  // The whole chain moves together unless a finished result is held.
  assign en         = !(chain_vld[BUCKETS] && out_stall_i);
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;

  assign full    = (count_q == CNT_W'(BUCKETS));
  assign bad_idx = (CMP_W'(in_data_i.bucket) >= CMP_W'(count_q));

  // Build the packet. Errors are settled here against the bucket count as
  // it stands when the transaction enters, which is the order of the chain.
  always_comb begin
    entry           = '0;
    entry.action    = in_data_i.action;
    entry.count     = count_q;
    entry.rate      = in_data_i.rate;
    entry.burst     = in_data_i.burst_limit;
    entry.amount    = in_data_i.amount;
    entry.status    = ST_OK;
    entry.new_index = '0;
    entry.granted   = '0;
    count_d         = count_q;
    unique case (in_data_i.action)
      ACT_TICK: begin
        entry.target = '0;
      end
      ACT_CREATE: begin
        if (full) begin
          entry.status = ST_ERROR;
        end else begin
          entry.target    = IDX_W'(count_q);
          entry.new_index = 4'(count_q);
          count_d         = count_q + CNT_W'(1);
        end
      end
      ACT_FETCH, ACT_RETURN: begin
        if (bad_idx) begin
          entry.status = ST_ERROR;
        end else begin
          entry.target = IDX_W'(in_data_i.bucket);
        end
      end
      default: begin
        entry.status = ST_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  assign chain_pkt[0] = entry;
  assign chain_vld[0] = in_valid_i;

  for (genvar i = 0; i < BUCKETS; i++) begin : g_cell
    mtbl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .cell_idx_i (IDX_W'(i)),
      .valid_i    (chain_vld[i]),
      .pkt_i      (chain_pkt[i]),
      .valid_o    (chain_vld[i+1]),
      .pkt_o      (chain_pkt[i+1])
    );
  end

  // The last cell's register doubles as the output register.
  assign out_valid_o          = chain_vld[BUCKETS];
  assign out_data_o.status    = chain_pkt[BUCKETS].status;
  assign out_data_o.new_index = chain_pkt[BUCKETS].new_index;
  assign out_data_o.granted   = chain_pkt[BUCKETS].granted;

endmodule
